// ===== sv/masked_byte_pattern_scanner_assert.svh =====
// Assertion macros for the masked byte pattern scanner checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mbps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mbps assertion failed");

`endif

// ===== sv/mbps_pkg.sv =====
// Shared types and constants of the masked byte pattern scanner.
// Used by the top level and by its checker; no dependencies.
package mbps_pkg;

	localparam int PAT_REG_BYTES    = 16;
	localparam int DEF_MAX_PATTERN  = 16;
	localparam int DEF_MAX_CAPTURE  = 8;
	localparam int DEF_OFFSET_WIDTH = 32;
	localparam int CFG_INDEX_W      = 3;
	localparam int CFG_DATA_W       = 64;

	localparam logic REC_MATCH   = 1'b0;
	localparam logic REC_SUMMARY = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW  = 3'd0,
		CFG_PATTERN_HIGH = 3'd1,
		CFG_CARE_MASK    = 3'd2,
		CFG_PATTERN_LEN  = 3'd3,
		CFG_CAPTURE_BEG  = 3'd4,
		CFG_CAPTURE_LEN  = 3'd5,
		CFG_FIND_ALL     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       scan_start;
		logic       end_of_region;
	} in_item_t;

	typedef struct packed {
		logic        record_kind;
		logic        hit_flag;
		logic [31:0] match_offset;
		logic [63:0] capture_value;
		logic        last_of_run;
	} out_item_t;

endpackage

// ===== sv/masked_byte_pattern_scanner.sv =====
// A byte is accepted into the input register, scanned from there into the scan state and the
// result queue, and its results can be taken from the result queue.
// Throughput: one byte per cycle, set by the combinational window compare; bytes stall
// only while three or more results wait in the four-entry result queue.
// Reset (arst_n low) clears the configuration, the input valid flag, the scan state and the result queue.
// Depends on mbps_pkg.
module masked_byte_pattern_scanner
	import mbps_pkg::*;
#(
	parameter int MAX_PATTERN       = DEF_MAX_PATTERN,
	parameter int MAX_CAPTURE_BYTES = DEF_MAX_CAPTURE,
	parameter int OFFSET_WIDTH      = DEF_OFFSET_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  in_item_t               byte_item,
	output logic                   rec_valid,
	input  logic                   rec_ready,
	output out_item_t              rec_item,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
	localparam int RES_DEPTH = 4;
	localparam int PTR_W     = $clog2(RES_DEPTH);
	localparam int CNT_W     = $clog2(RES_DEPTH + 1);

	// Configuration registers
	logic [63:0] pat_lo_q, pat_hi_q;
	logic [15:0] care_q;
	logic [4:0]  plen_q;
	logic [3:0]  cap_begin_q, cap_len_q;
	logic        find_all_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q    <= '0;
			pat_hi_q    <= '0;
			care_q      <= '0;
			plen_q      <= '0;
			cap_begin_q <= '0;
			cap_len_q   <= '0;
			find_all_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_LOW:  pat_lo_q    <= cfg_data;
				CFG_PATTERN_HIGH: pat_hi_q    <= cfg_data;
				CFG_CARE_MASK:    care_q      <= cfg_data[15:0];
				CFG_PATTERN_LEN:  plen_q      <= cfg_data[4:0];
				CFG_CAPTURE_BEG:  cap_begin_q <= cfg_data[3:0];
				CFG_CAPTURE_LEN:  cap_len_q   <= cfg_data[3:0];
				CFG_FIND_ALL:     find_all_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [8*PAT_REG_BYTES-1:0] pat_bytes;
	assign pat_bytes = {pat_hi_q, pat_lo_q};

	// Input register
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic [CNT_W-1:0] count_q;

	assign advance    = valid_s1 && (count_q <= CNT_W'(RES_DEPTH - 2));
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	// Scan state
	logic [7:0]              win_q [MAX_PATTERN];
	logic [FILL_W-1:0]       fill_q;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic                    any_q, stopped_q;

	logic [7:0]              win_eff [MAX_PATTERN];
	logic [7:0]              win_new [MAX_PATTERN];
	logic [FILL_W-1:0]       fill_eff, fill_new;
	logic [OFFSET_WIDTH-1:0] pos_eff, off_w;
	logic [63:0]             off_ext;
	logic                    any_eff, stop_eff, start;
	logic                    len_ok, match_hit, go, has_match, has_sum;
	logic [3:0]              cl_eff;
	logic [63:0]             capture;
	out_item_t               match_rec, sum_rec;

	// A scan start clears the state before the byte itself is scanned.
	assign start    = item_s1.scan_start;
	assign fill_eff = start ? '0 : fill_q;
	assign pos_eff  = start ? '0 : pos_q;
	assign any_eff  = start ? 1'b0 : any_q;
	assign stop_eff = start ? 1'b0 : stopped_q;

	always_comb begin
		win_new[0] = item_s1.data_byte;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			win_eff[k] = start ? 8'h00 : win_q[k];
		end
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_new[k] = win_eff[k-1];
		end
	end

	assign fill_new = (fill_eff == FILL_W'(MAX_PATTERN)) ? fill_eff : fill_eff + FILL_W'(1);
	assign len_ok   = (plen_q != 5'd0) && (7'(plen_q) <= 7'(MAX_PATTERN))
		&& (7'(fill_new) >= 7'(plen_q));

	// Pattern byte i sits at window position plen-1-i, the newest byte at 0.
	always_comb begin
		logic [6:0] widx;
		logic [7:0] wbyte;
		match_hit = len_ok;
		for (int i = 0; i < PAT_REG_BYTES; i++) begin
			widx  = 7'(plen_q) - 7'd1 - 7'(i);
			wbyte = 8'h00;
			if (widx < 7'(MAX_PATTERN)) begin
				wbyte = win_new[widx[IDX_W-1:0]];
			end
			if (care_q[i] && (7'(i) < 7'(plen_q)) && (wbyte != pat_bytes[8*i +: 8])) begin
				match_hit = 1'b0;
			end
		end
	end

	assign cl_eff = (cap_len_q > 4'(MAX_CAPTURE_BYTES)) ? 4'(MAX_CAPTURE_BYTES) : cap_len_q;

	always_comb begin
		logic [6:0] pidx, cidx;
		logic [7:0] cbyte;
		capture = '0;
		for (int j = 0; j < MAX_CAPTURE_BYTES; j++) begin
			pidx  = 7'(cap_begin_q) + 7'(j);
			cidx  = 7'(plen_q) - 7'd1 - pidx;
			cbyte = 8'h00;
			if ((4'(j) < cl_eff) && (pidx < 7'(plen_q)) && (cidx < 7'(MAX_PATTERN))) begin
				cbyte = win_new[cidx[IDX_W-1:0]];
			end
			capture[8*j +: 8] = cbyte;
		end
	end

	assign off_w   = pos_eff - OFFSET_WIDTH'(plen_q) + OFFSET_WIDTH'(1);
	assign off_ext = 64'(off_w);

	assign go        = advance && !stop_eff;
	assign has_match = go && match_hit;
	assign has_sum   = go && item_s1.end_of_region && !(has_match && !find_all_q);

	always_comb begin
		match_rec               = '0;
		match_rec.record_kind   = REC_MATCH;
		match_rec.hit_flag      = 1'b1;
		match_rec.match_offset  = off_ext[31:0];
		match_rec.capture_value = capture;
		match_rec.last_of_run   = !find_all_q;
		sum_rec                 = '0;
		sum_rec.record_kind     = REC_SUMMARY;
		sum_rec.hit_flag        = any_eff || has_match;
		sum_rec.last_of_run     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= 8'h00;
			end
			fill_q    <= '0;
			pos_q     <= '0;
			any_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else if (go) begin
			win_q     <= win_new;
			fill_q    <= fill_new;
			pos_q     <= pos_eff + OFFSET_WIDTH'(1);
			any_q     <= any_eff || has_match;
			stopped_q <= (has_match && !find_all_q) || item_s1.end_of_region;
		end
	end

	// Result queue: up to two items enter per byte, at most one leaves per cycle, when rec_ready is high.
	out_item_t        res_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [1:0]       push_n;
	logic             pop;

	assign push_n    = {1'b0, has_match} + {1'b0, has_sum};
	assign rec_valid = (count_q != '0);
	assign rec_item  = res_q[rd_q];
	assign pop       = rec_valid && rec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push_n);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (has_match) begin
			res_q[wr_q] <= match_rec;
		end
		if (has_sum) begin
			res_q[wr_q + PTR_W'(has_match)] <= sum_rec;
		end
	end

endmodule

// ===== sv/mbps_checker.sv =====
// Port-level checker for the masked byte pattern scanner, bound to the top level.
// Depends on mbps_pkg and masked_byte_pattern_scanner_assert.svh.
`include "masked_byte_pattern_scanner_assert.svh"
module mbps_checker
	import mbps_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      byte_ready,
	input logic      rec_valid,
	input logic      rec_ready,
	input out_item_t rec_item
);

	logic rec_is_summary, rec_is_match, summary_clean, rec_waiting;

	assign rec_is_summary = rec_valid && (rec_item.record_kind == REC_SUMMARY);
	assign rec_is_match   = rec_valid && (rec_item.record_kind == REC_MATCH);
	assign summary_clean  = (rec_item.match_offset == 32'd0)
		&& (rec_item.capture_value == 64'd0) && rec_item.last_of_run;
	assign rec_waiting    = rec_valid && !rec_ready;

	// A summary carries no offset or capture and always closes the run.
	`MBPS_ASSERT_SAME(a_summary_form, clk, arst_n, rec_is_summary, summary_clean)

	// Every match record reports a hit.
	`MBPS_ASSERT_SAME(a_match_found, clk, arst_n, rec_is_match, rec_item.hit_flag)

	// The byte side only stalls while results are waiting to be taken.
	`MBPS_ASSERT_SAME(a_stall_has_backlog, clk, arst_n, !byte_ready, rec_valid)

	// A result that is not taken stays unchanged.
	`MBPS_ASSERT_NEXT(a_rec_hold, clk, arst_n, rec_waiting, rec_valid && $stable(rec_item))

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
